### hw/rtl/tpd_pkg.sv
// Package for the tracking packet deframer.
// Item, record and queue entry types, phase and code enums, register defaults.
// No dependencies.
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int CFG_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT = CFG_IDX_W'(1);

    localparam logic [31:0] MAGIC_RESET = 32'h5246_5056;
    localparam logic [7:0]  LIMIT_RESET = 8'd52;
    localparam int          MIN_PACKET  = 16;
    localparam logic [1:0]  AXES        = 2'd3;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_TIME    = 3'd1,
        PH_WCOUNT  = 3'd2,
        PH_WEIGHTS = 3'd3,
        PH_PCOUNT  = 3'd4,
        PH_POSE    = 3'd5,
        PH_TAIL    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_TIME   = 3'd0,
        KIND_WEIGHT = 3'd1,
        KIND_POSE_X = 3'd2,
        KIND_POSE_Y = 3'd3,
        KIND_POSE_Z = 3'd4,
        KIND_END    = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_MAGIC    = 3'd2,
        ST_WEIGHT_SHORT = 3'd3,
        ST_NO_POSE_CNT  = 3'd4,
        ST_POSE_SHORT   = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] element_index;
        logic [63:0] raw_value;
        logic [2:0]  packet_status;
        logic        end_of_packet;
    } t_out_item;

    // one entry per byte that causes output: a data record, a status, or both
    typedef struct packed {
        logic      has_rec;
        t_out_item rec;
        logic      has_stat;
        t_status   stat;
    } t_event;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

endpackage

### hw/rtl/tpd_parser.sv
// Front part of the deframer: byte parser, field assembly and status check.
// Holds the configuration registers. Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_parser #(
    parameter int LENGTH_WIDTH = 21
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  tpd_pkg::t_in_item              i_item,
    input  logic                           i_cfg_write,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_evt_valid,
    output tpd_pkg::t_event                o_evt
);

    localparam int SUMW = ((LENGTH_WIDTH > 20) ? LENGTH_WIDTH : 20) + 1;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

    tpd_pkg::t_phase         r_phase, n_phase;
    logic [3:0]              r_fbc, n_fbc;
    logic [63:0]             r_acc, n_acc;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic                    r_magic_good, n_magic_good;
    logic [15:0]             r_wcount, n_wcount;
    logic [15:0]             r_widx, n_widx;
    logic [15:0]             r_lcount, n_lcount;
    logic [15:0]             r_lidx, n_lidx;
    logic [1:0]              r_axis, n_axis;
    logic [LENGTH_WIDTH-1:0] r_wend, n_wend;
    logic [LENGTH_WIDTH-1:0] r_pend, n_pend;
    logic [31:0]             r_magic_word;
    logic [7:0]              r_name_limit;

    logic [SUMW-1:0]         w_sum;
    logic [SUMW-1:0]         p_sum;
    tpd_pkg::t_event         evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word <= tpd_pkg::MAGIC_RESET;
            r_name_limit <= tpd_pkg::LIMIT_RESET;
        end else if (i_cfg_write) begin
            if (i_cfg_index == tpd_pkg::CFG_MAGIC_WORD) begin
                r_magic_word <= i_cfg_data;
            end else if (i_cfg_index == tpd_pkg::CFG_NAME_LIMIT) begin
                r_name_limit <= i_cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tpd_pkg::PH_MAGIC;
            r_fbc        <= '0;
            r_acc        <= '0;
            r_len        <= '0;
            r_magic_good <= 1'b1;
            r_wcount     <= '0;
            r_widx       <= '0;
            r_lcount     <= '0;
            r_lidx       <= '0;
            r_axis       <= '0;
            r_wend       <= '0;
            r_pend       <= '0;
        end else begin
            r_phase      <= n_phase;
            r_fbc        <= n_fbc;
            r_acc        <= n_acc;
            r_len        <= n_len;
            r_magic_good <= n_magic_good;
            r_wcount     <= n_wcount;
            r_widx       <= n_widx;
            r_lcount     <= n_lcount;
            r_lidx       <= n_lidx;
            r_axis       <= n_axis;
            r_wend       <= n_wend;
            r_pend       <= n_pend;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_fbc        = r_fbc;
        n_acc        = r_acc;
        n_len        = r_len;
        n_magic_good = r_magic_good;
        n_wcount     = r_wcount;
        n_widx       = r_widx;
        n_lcount     = r_lcount;
        n_lidx       = r_lidx;
        n_axis       = r_axis;
        n_wend       = r_wend;
        n_pend       = r_pend;
        w_sum        = '0;
        p_sum        = '0;
        evt          = '0;

        if (i_accept) begin
            if (r_len != LEN_MAX) begin
                n_len = r_len + LENGTH_WIDTH'(1);
            end

            if (r_phase != tpd_pkg::PH_MAGIC && r_phase != tpd_pkg::PH_TAIL) begin
                for (int k = 0; k < 8; k++) begin
                    if (r_fbc[2:0] == 3'(k)) begin
                        n_acc[8*k +: 8] = r_acc[8*k +: 8] | i_item.data_byte;
                    end
                end
                n_fbc = r_fbc + 4'd1;
            end

            case (r_phase)
                tpd_pkg::PH_MAGIC: begin
                    if (i_item.data_byte != r_magic_word[8*r_fbc[1:0] +: 8]) begin
                        n_magic_good = 1'b0;
                    end
                    n_fbc = r_fbc + 4'd1;
                    if (n_fbc >= 4'd4) begin
                        n_fbc   = '0;
                        n_acc   = '0;
                        n_phase = tpd_pkg::PH_TIME;
                    end
                end
                tpd_pkg::PH_TIME: begin
                    if (n_fbc >= 4'd8) begin
                        evt.has_rec               = 1'b1;
                        evt.rec.record_kind       = tpd_pkg::KIND_TIME;
                        evt.rec.raw_value         = n_acc;
                        n_fbc   = '0;
                        n_acc   = '0;
                        n_phase = tpd_pkg::PH_WCOUNT;
                    end
                end
                tpd_pkg::PH_WCOUNT: begin
                    if (n_fbc >= 4'd2) begin
                        n_wcount = n_acc[15:0];
                        w_sum    = SUMW'(n_len) + SUMW'({n_acc[15:0], 2'b00});
                        n_wend   = (w_sum > SUMW'(LEN_MAX)) ? LEN_MAX
                                                            : w_sum[LENGTH_WIDTH-1:0];
                        n_widx   = '0;
                        n_fbc    = '0;
                        n_acc    = '0;
                        if (n_wcount == 16'd0 || r_name_limit == 8'd0) begin
                            n_phase = tpd_pkg::PH_PCOUNT;
                        end else begin
                            n_phase = tpd_pkg::PH_WEIGHTS;
                        end
                    end
                end
                tpd_pkg::PH_WEIGHTS: begin
                    if (n_fbc >= 4'd4) begin
                        evt.has_rec               = 1'b1;
                        evt.rec.record_kind       = tpd_pkg::KIND_WEIGHT;
                        evt.rec.element_index     = r_widx;
                        evt.rec.raw_value         = {32'd0, n_acc[31:0]};
                        n_widx = r_widx + 16'd1;
                        n_fbc  = '0;
                        n_acc  = '0;
                        if (n_widx >= r_wcount || n_widx >= 16'(r_name_limit)) begin
                            n_phase = tpd_pkg::PH_PCOUNT;
                        end
                    end
                end
                tpd_pkg::PH_PCOUNT: begin
                    if (n_fbc >= 4'd2) begin
                        n_lcount = n_acc[15:0];
                        p_sum    = SUMW'(n_len) + SUMW'({n_acc[15:0], 3'b000})
                                 + SUMW'({n_acc[15:0], 2'b00});
                        n_pend   = (p_sum > SUMW'(LEN_MAX)) ? LEN_MAX
                                                            : p_sum[LENGTH_WIDTH-1:0];
                        n_lidx   = '0;
                        n_axis   = '0;
                        n_fbc    = '0;
                        n_acc    = '0;
                        n_phase  = (n_lcount == 16'd0) ? tpd_pkg::PH_TAIL
                                                       : tpd_pkg::PH_POSE;
                    end
                end
                tpd_pkg::PH_POSE: begin
                    if (n_fbc >= 4'd4) begin
                        evt.has_rec               = 1'b1;
                        evt.rec.record_kind       = 3'(tpd_pkg::KIND_POSE_X) + 3'(r_axis);
                        evt.rec.element_index     = r_lidx;
                        evt.rec.raw_value         = {32'd0, n_acc[31:0]};
                        n_fbc  = '0;
                        n_acc  = '0;
                        n_axis = r_axis + 2'd1;
                        if (n_axis >= tpd_pkg::AXES) begin
                            n_axis = '0;
                            n_lidx = r_lidx + 16'd1;
                            if (n_lidx >= r_lcount) begin
                                n_phase = tpd_pkg::PH_TAIL;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if (i_item.last_byte) begin
                evt.has_stat = 1'b1;
                if (n_len < LENGTH_WIDTH'(tpd_pkg::MIN_PACKET)) begin
                    evt.stat = tpd_pkg::ST_TOO_SHORT;
                end else if (!n_magic_good) begin
                    evt.stat = tpd_pkg::ST_BAD_MAGIC;
                end else if (n_wend > n_len) begin
                    evt.stat = tpd_pkg::ST_WEIGHT_SHORT;
                end else if (n_phase != tpd_pkg::PH_POSE && n_phase != tpd_pkg::PH_TAIL) begin
                    evt.stat = tpd_pkg::ST_NO_POSE_CNT;
                end else if (n_pend > n_len) begin
                    evt.stat = tpd_pkg::ST_POSE_SHORT;
                end else begin
                    evt.stat = tpd_pkg::ST_OK;
                end
                n_phase      = tpd_pkg::PH_MAGIC;
                n_fbc        = '0;
                n_acc        = '0;
                n_len        = '0;
                n_magic_good = 1'b1;
                n_wcount     = '0;
                n_widx       = '0;
                n_lcount     = '0;
                n_lidx       = '0;
                n_axis       = '0;
                n_wend       = '0;
                n_pend       = '0;
            end
        end
    end

    assign o_evt       = evt;
    assign o_evt_valid = evt.has_rec | evt.has_stat;

endmodule

### hw/rtl/tpd_queue.sv
// Short event queue between the parser and the record emitter.
// Register file with read and write pointers. Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tpd_pkg::t_event   i_evt,
    input  logic              i_pop,
    output tpd_pkg::t_event   o_head,
    output tpd_pkg::t_q_flags o_flags
);

    tpd_pkg::t_event                r_mem [tpd_pkg::QUEUE_DEPTH];
    logic [tpd_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [tpd_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [tpd_pkg::QPTR_W:0]       r_count, n_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == (tpd_pkg::QPTR_W+1)'(tpd_pkg::QUEUE_DEPTH));
    assign do_push       = i_push & ~o_flags.full;
    assign do_pop        = i_pop & ~o_flags.empty;
    assign o_head        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### hw/rtl/tpd_emitter.sv
// Back part of the deframer: turns queue entries into output records.
// Data record first, then the status record; output register. Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_emitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpd_pkg::t_event   i_head,
    input  tpd_pkg::t_q_flags i_flags,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tpd_pkg::t_out_item o_out
);

    logic               r_out_valid, n_out_valid;
    tpd_pkg::t_out_item r_out, n_out;
    logic               r_rec_done, n_rec_done;
    logic               can_load;

    assign can_load = ~r_out_valid | ~i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;
        n_rec_done  = r_rec_done;
        o_pop       = 1'b0;
        if (can_load && !i_flags.empty) begin
            n_out_valid = 1'b1;
            if (i_head.has_rec && !r_rec_done) begin
                n_out = i_head.rec;
                if (i_head.has_stat) begin
                    n_rec_done = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_out               = '0;
                n_out.record_kind   = tpd_pkg::KIND_END;
                n_out.packet_status = i_head.stat;
                n_out.end_of_packet = 1'b1;
                n_rec_done          = 1'b0;
                o_pop               = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rec_done  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_rec_done  <= n_rec_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### hw/rtl/tracking_packet_deframer.sv
// Top level of the tracking packet deframer: parser, event queue, emitter.
// Depends on tpd_pkg, tpd_parser, tpd_queue, tpd_emitter.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+------------------------------
//   in      | input     | i_in_valid/o_in_stall   | one datagram byte + last mark
//   out     | output    | o_out_valid/i_out_stall | one record
//   cfg     | input     | i_cfg_valid/o_cfg_ready | register index + write data
//
// One byte per cycle unless the event queue is full; its records go through the
// queue to the output register. A last byte closing a field yields two records.
// The input stalls only while the four-entry event queue is full.
// Synchronous active-low reset; configuration registers return to defaults.
`timescale 1ns / 1ps

module tracking_packet_deframer #(
    parameter int LENGTH_WIDTH = 21
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tpd_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tpd_pkg::t_out_item             o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    logic              in_accept;
    logic              evt_valid;
    tpd_pkg::t_event   evt;
    tpd_pkg::t_event   head;
    tpd_pkg::t_q_flags flags;
    logic              pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = flags.full;
    assign in_accept   = i_in_valid & ~flags.full;

    tpd_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in),
        .i_cfg_write (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_evt_valid (evt_valid),
        .o_evt       (evt)
    );

    tpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_valid),
        .i_evt   (evt),
        .i_pop   (pop),
        .o_head  (head),
        .o_flags (flags)
    );

    tpd_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_flags     (flags),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

### hw/rtl/tpd_checker.sv
// Port-level assertions for the tracking packet deframer, bound to the top.
// Depends on tpd_pkg and tracking_packet_deframer.
`timescale 1ns / 1ps

module tpd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tpd_pkg::t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output beat changed");

    a_eop_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.end_of_packet == (o_out.record_kind == tpd_pkg::KIND_END)))
        else $error("end mark does not match status kind");

    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.end_of_packet |-> o_out.packet_status == tpd_pkg::ST_OK)
        else $error("status on a data record");

    a_status_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.end_of_packet
            |-> o_out.raw_value == 64'd0 && o_out.element_index == 16'd0)
        else $error("payload on a status record");

endmodule

bind tracking_packet_deframer tpd_checker u_tpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

### dv/tracking_packet_deframer_tb.sv
// Self-checking testbench for tracking_packet_deframer: directed and random datagrams,
// register writes between phases, random idling on both sides, per-field record checks.
// Depends on tpd_pkg and the tracking_packet_deframer RTL.
`timescale 1ns / 1ps

module tracking_packet_deframer_tb;

    localparam int LENGTH_WIDTH = 21;
    localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_WIDTH) - 1;
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED = 100;
    localparam int MAX_BUILT_WEIGHTS = 16;
    localparam int MAX_BUILT_LANDMARKS = 4;
    localparam int COUNT_MAX = 65535;
    localparam int PHASE_BYTES = 380;
    localparam logic [tpd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LAST = '1;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    tpd_pkg::t_in_item             i_in = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    tpd_pkg::t_out_item            o_out;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [tpd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]                   i_cfg_data = '0;

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int error_count = 0;
    int idle_cycles = 0;

    tpd_pkg::t_out_item expected_records[$];
    logic [7:0]         frame_q[$];

    // shadow registers and parse state
    logic [31:0]     shadow_magic;
    logic [7:0]      shadow_limit;
    tpd_pkg::t_phase ph;
    logic [3:0]      byte_ctr;
    logic [63:0]     field_acc;
    longint unsigned pkt_len;
    longint unsigned wt_end;
    longint unsigned lm_end;
    logic            magic_match;
    logic [15:0]     wt_declared;
    logic [15:0]     wt_idx;
    logic [15:0]     lm_declared;
    logic [15:0]     lm_idx;
    logic [1:0]      axis;

    tracking_packet_deframer #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint unsigned sat_len(input longint unsigned v);
        return (v > LEN_MAX) ? LEN_MAX : v;
    endfunction

    function automatic int weights_to_take();
        return (wt_declared < shadow_limit) ? int'(wt_declared) : int'(shadow_limit);
    endfunction

    function automatic void clear_packet();
        ph = tpd_pkg::PH_MAGIC;
        byte_ctr = '0;
        field_acc = '0;
        pkt_len = 0;
        magic_match = 1'b1;
        wt_declared = '0;
        wt_idx = '0;
        lm_declared = '0;
        lm_idx = '0;
        axis = '0;
        wt_end = 0;
        lm_end = 0;
    endfunction

    function automatic void push_record(input tpd_pkg::t_kind kind,
                                        input logic [15:0] index,
                                        input logic [63:0] raw, input tpd_pkg::t_status st,
                                        input logic eop);
        tpd_pkg::t_out_item rec;
        rec.record_kind = kind;
        rec.element_index = index;
        rec.raw_value = raw;
        rec.packet_status = st;
        rec.end_of_packet = eop;
        expected_records.push_back(rec);
    endfunction

    // expected records for one accepted byte
    function automatic void deframe_byte(input logic [7:0] b, input logic last);
        tpd_pkg::t_status st;
        if (pkt_len < LEN_MAX)
            pkt_len++;
        if (ph != tpd_pkg::PH_MAGIC && ph != tpd_pkg::PH_TAIL) begin
            field_acc |= 64'(b) << (8 * byte_ctr[2:0]);
            byte_ctr++;
        end
        case (ph)
            tpd_pkg::PH_MAGIC: begin
                if (b != shadow_magic[8 * byte_ctr[1:0] +: 8])
                    magic_match = 1'b0;
                byte_ctr++;
                if (byte_ctr >= 4) begin
                    byte_ctr = '0;
                    field_acc = '0;
                    ph = tpd_pkg::PH_TIME;
                end
            end
            tpd_pkg::PH_TIME: begin
                if (byte_ctr >= 8) begin
                    push_record(tpd_pkg::KIND_TIME, '0, field_acc, tpd_pkg::ST_OK, 1'b0);
                    byte_ctr = '0;
                    field_acc = '0;
                    ph = tpd_pkg::PH_WCOUNT;
                end
            end
            tpd_pkg::PH_WCOUNT: begin
                if (byte_ctr >= 2) begin
                    wt_declared = field_acc[15:0];
                    wt_end = sat_len(pkt_len + 64'(wt_declared) * 4);
                    wt_idx = '0;
                    byte_ctr = '0;
                    field_acc = '0;
                    ph = (weights_to_take() == 0) ? tpd_pkg::PH_PCOUNT : tpd_pkg::PH_WEIGHTS;
                end
            end
            tpd_pkg::PH_WEIGHTS: begin
                if (byte_ctr >= 4) begin
                    push_record(tpd_pkg::KIND_WEIGHT, wt_idx, {32'd0, field_acc[31:0]},
                                tpd_pkg::ST_OK, 1'b0);
                    wt_idx++;
                    byte_ctr = '0;
                    field_acc = '0;
                    if (wt_idx >= weights_to_take())
                        ph = tpd_pkg::PH_PCOUNT;
                end
            end
            tpd_pkg::PH_PCOUNT: begin
                if (byte_ctr >= 2) begin
                    lm_declared = field_acc[15:0];
                    lm_end = sat_len(pkt_len + 64'(lm_declared) * 12);
                    lm_idx = '0;
                    axis = '0;
                    byte_ctr = '0;
                    field_acc = '0;
                    ph = (lm_declared == 0) ? tpd_pkg::PH_TAIL : tpd_pkg::PH_POSE;
                end
            end
            tpd_pkg::PH_POSE: begin
                if (byte_ctr >= 4) begin
                    push_record(tpd_pkg::t_kind'(tpd_pkg::KIND_POSE_X + axis), lm_idx,
                                {32'd0, field_acc[31:0]}, tpd_pkg::ST_OK, 1'b0);
                    byte_ctr = '0;
                    field_acc = '0;
                    axis++;
                    if (axis >= tpd_pkg::AXES) begin
                        axis = '0;
                        lm_idx++;
                        if (lm_idx >= lm_declared)
                            ph = tpd_pkg::PH_TAIL;
                    end
                end
            end
            default: ;
        endcase
        if (last) begin
            if (pkt_len < tpd_pkg::MIN_PACKET)
                st = tpd_pkg::ST_TOO_SHORT;
            else if (!magic_match)
                st = tpd_pkg::ST_BAD_MAGIC;
            else if (wt_end > pkt_len)
                st = tpd_pkg::ST_WEIGHT_SHORT;
            else if (ph != tpd_pkg::PH_POSE && ph != tpd_pkg::PH_TAIL)
                st = tpd_pkg::ST_NO_POSE_CNT;
            else if (lm_end > pkt_len)
                st = tpd_pkg::ST_POSE_SHORT;
            else
                st = tpd_pkg::ST_OK;
            push_record(tpd_pkg::KIND_END, '0, '0, st, 1'b1);
            clear_packet();
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_PRINTED)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        error_count++;
    endtask

    task automatic check_record(input tpd_pkg::t_out_item got);
        tpd_pkg::t_out_item want;
        if (expected_records.size() == 0) begin
            report_mismatch("record with none pending, kind", 64'(got.record_kind), '0);
            return;
        end
        want = expected_records.pop_front();
        if (got.record_kind !== want.record_kind)
            report_mismatch("record_kind", 64'(got.record_kind), 64'(want.record_kind));
        if (got.element_index !== want.element_index)
            report_mismatch("element_index", 64'(got.element_index), 64'(want.element_index));
        if (got.raw_value !== want.raw_value)
            report_mismatch("raw_value", got.raw_value, want.raw_value);
        if (got.packet_status !== want.packet_status)
            report_mismatch("packet_status", 64'(got.packet_status), 64'(want.packet_status));
        if (got.end_of_packet !== want.end_of_packet)
            report_mismatch("end_of_packet", 64'(got.end_of_packet), 64'(want.end_of_packet));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            check_record(o_out);
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input beat per call
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{data_byte: data, last_byte: last};
        do @(posedge i_clk); while (o_in_stall);
        deframe_byte(data, last);
    endtask

    task automatic send_frame(input int keep);
        for (int i = 0; i < keep; i++)
            send_byte(frame_q[i], i == keep - 1);
    endtask

    task automatic build_frame(input int wcount, input int lcount, input bit bad_magic,
                               input int pad);
        int take;
        int pos;
        frame_q.delete();
        for (int i = 0; i < 4; i++)
            frame_q.push_back(shadow_magic[8 * i +: 8]);
        if (bad_magic) begin
            pos = $urandom_range(3);
            frame_q[pos] = frame_q[pos] ^ (8'd1 << $urandom_range(7));
        end
        for (int i = 0; i < 8; i++)
            frame_q.push_back(8'($urandom()));
        frame_q.push_back(wcount[7:0]);
        frame_q.push_back(wcount[15:8]);
        take = (wcount < shadow_limit) ? wcount : int'(shadow_limit);
        if (take > MAX_BUILT_WEIGHTS)
            take = MAX_BUILT_WEIGHTS;
        for (int i = 0; i < 4 * take; i++)
            frame_q.push_back(8'($urandom()));
        frame_q.push_back(lcount[7:0]);
        frame_q.push_back(lcount[15:8]);
        for (int i = 0; i < 12 * ((lcount < MAX_BUILT_LANDMARKS) ? lcount : MAX_BUILT_LANDMARKS);
             i++)
            frame_q.push_back(8'($urandom()));
        for (int i = 0; i < pad; i++)
            frame_q.push_back(8'($urandom()));
    endtask

    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [tpd_pkg::CFG_IDX_W-1:0] index,
                                  input logic [31:0] data);
        wait_until_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            tpd_pkg::CFG_MAGIC_WORD: shadow_magic = data;
            tpd_pkg::CFG_NAME_LIMIT: shadow_limit = data[7:0];
            default: ;
        endcase
    endtask

    task automatic test_directed_frames();
        build_frame(0, 0, 1'b0, 0);
        send_frame(frame_q.size());
        frame_q = '{8'hFF};
        send_frame(1);
        build_frame(0, 0, 1'b0, 0);
        send_frame(tpd_pkg::MIN_PACKET - 1);
        build_frame(0, 0, 1'b1, 0);
        send_frame(frame_q.size());
        build_frame(1, 0, 1'b0, 0);
        send_frame(tpd_pkg::MIN_PACKET);
        build_frame(1, 0, 1'b0, 0);
        send_frame(tpd_pkg::MIN_PACKET + 2);
        build_frame(0, 1, 1'b0, 0);
        send_frame(tpd_pkg::MIN_PACKET + 4);
        // last byte closes a pose z word: record then status on one beat
        build_frame(1, 1, 1'b0, 0);
        send_frame(frame_q.size());
        frame_q = '{8'h00};
        send_frame(1);
    endtask

    task automatic test_register_writes();
        write_register(tpd_pkg::CFG_MAGIC_WORD, 32'h0000_0000);
        build_frame(0, 0, 1'b0, 0);
        send_frame(frame_q.size());
        write_register(tpd_pkg::CFG_MAGIC_WORD, 32'hFFFF_FFFF);
        build_frame(1, 1, 1'b0, 0);
        send_frame(frame_q.size());
        build_frame(0, 0, 1'b1, 0);
        send_frame(frame_q.size());
        write_register(tpd_pkg::CFG_NAME_LIMIT, 32'd0);
        build_frame(3, 1, 1'b0, 12);
        send_frame(frame_q.size());
        write_register(tpd_pkg::CFG_NAME_LIMIT, 32'hFFFF_FFFF);
        build_frame(5, 1, 1'b0, 0);
        send_frame(frame_q.size());
        write_register(tpd_pkg::CFG_IDX_W'($urandom_range(int'(tpd_pkg::CFG_NAME_LIMIT) + 1,
                                                          int'(CFG_UNUSED_LAST))),
                       $urandom());
        build_frame(2, 0, 1'b0, 0);
        send_frame(frame_q.size());
    endtask

    task automatic test_random_traffic(input int n_bytes, input int idle_pct,
                                       input int stall_pct);
        int sent;
        int pick;
        int wcount;
        int lcount;
        int take;
        int pad;
        int keep;
        in_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                frame_q.delete();
                if ($urandom_range(3) == 0) begin
                    for (int i = 0; i < 4; i++)
                        frame_q.push_back(shadow_magic[8 * i +: 8]);
                end
                repeat ($urandom_range(1, 24))
                    frame_q.push_back(8'($urandom()));
                keep = frame_q.size();
            end else begin
                pick = $urandom_range(99);
                wcount = (pick < 80) ? $urandom_range(0, 6)
                       : (pick < 90) ? $urandom_range(0, COUNT_MAX) : COUNT_MAX;
                pick = $urandom_range(99);
                lcount = (pick < 85) ? $urandom_range(0, 4)
                       : (pick < 93) ? $urandom_range(0, COUNT_MAX) : COUNT_MAX;
                take = (wcount < shadow_limit) ? wcount : int'(shadow_limit);
                pad = $urandom_range(0, 3);
                // cover the declared but unread weight bytes
                if (wcount > take && wcount - take <= 32 && $urandom_range(1) == 1)
                    pad += 4 * (wcount - take);
                build_frame(wcount, lcount, $urandom_range(99) < 8, pad);
                keep = ($urandom_range(99) < 20) ? $urandom_range(1, frame_q.size())
                                                 : frame_q.size();
            end
            send_frame(keep);
            sent += keep;
        end
    endtask

    initial begin
        shadow_magic = tpd_pkg::MAGIC_RESET;
        shadow_limit = tpd_pkg::LIMIT_RESET;
        clear_packet();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_register_writes();

        write_register(tpd_pkg::CFG_MAGIC_WORD, tpd_pkg::MAGIC_RESET);
        write_register(tpd_pkg::CFG_NAME_LIMIT, 32'(tpd_pkg::LIMIT_RESET));
        test_random_traffic(PHASE_BYTES, 0, 0);

        write_register(tpd_pkg::CFG_MAGIC_WORD, $urandom());
        write_register(tpd_pkg::CFG_NAME_LIMIT, 32'd0);
        test_random_traffic(PHASE_BYTES, 75, 0);

        write_register(tpd_pkg::CFG_NAME_LIMIT, 32'd255);
        test_random_traffic(PHASE_BYTES, 0, 75);

        write_register(tpd_pkg::CFG_MAGIC_WORD, $urandom());
        write_register(tpd_pkg::CFG_NAME_LIMIT, 32'($urandom_range(0, 8)));
        test_random_traffic(PHASE_BYTES, 14, 14);

        wait_until_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### tracking_packet_deframer.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_parser.sv
hw/rtl/tpd_queue.sv
hw/rtl/tpd_emitter.sv
hw/rtl/tracking_packet_deframer.sv
hw/rtl/tpd_checker.sv
dv/tracking_packet_deframer_tb.sv
